/* rtl/sdq_pkg.sv */
// Package for the searchable deque: request codes, status codes, port widths and the
// default sizes handed to the top level. No dependencies.
package sdq_pkg;

  // Default sizes
  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int REQ_W    = 3;
  localparam int KEY_IN_W = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd6;
  localparam logic [REQ_W-1:0] REQ_FIND       = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

/* rtl/sdq_store.sv */
// Entry store of the searchable deque: one write port and one read port
// with registered read data. No package dependencies.
module sdq_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/searchable_deque.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | req_type, key_in
// out     | output    | out_valid/out_ready | value_out, found, status, entry_count
//
// One request is in work at a time. Push: S_IDLE, then S_DONE. Pop or peek: S_IDLE,
// S_READ, S_DONE; S_READ is skipped when empty. Find: S_SCAN with one store read per
// entry scanned from the back, then S_DONE. Remove: the scan, then, when entries lie
// behind the match, S_SHIFT moves each such entry one slot toward the front through
// the single store read and write port, with the last write-back in its final step.
// Reset clears the front index, the count and all handshake state; the store
// holds no reset. A waiting result holds the block only at its final step.
// Depends on sdq_pkg and sdq_store.
module searchable_deque #(
  parameter int DEPTH     = sdq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = sdq_pkg::KEY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sdq_pkg::REQ_W-1:0]       req_type,
  input  logic [sdq_pkg::KEY_IN_W-1:0]    key_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sdq_pkg::VALUE_W-1:0]     value_out,
  output logic                            found,
  output logic [sdq_pkg::STATUS_W-1:0]    status,
  output logic [sdq_pkg::COUNT_W-1:0]     entry_count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Physical slot of a logical position counted from the front
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] f,
                                               input logic [CNT_W-1:0] p);
    logic [SUM_W-1:0] s;
    s = SUM_W'(f) + SUM_W'(p);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return PTR_W'(s);
  endfunction

  state_t                        state;
  logic [PTR_W-1:0]              front;
  logic [CNT_W-1:0]              occ;
  logic [CNT_W-1:0]              pos;
  logic                          chk_vld;
  logic [CNT_W-1:0]              chk_pos;
  logic [PTR_W-1:0]              chk_slot;
  logic                          sh_vld;
  logic [PTR_W-1:0]              sh_dst;
  logic [sdq_pkg::REQ_W-1:0]     req_r;
  logic [KEY_WIDTH-1:0]          key_r;
  logic [sdq_pkg::VALUE_W-1:0]   res_value;
  logic                          res_found;
  logic [sdq_pkg::STATUS_W-1:0]  res_status;

  logic                          accept;
  logic                          full;
  logic                          empty;
  logic [KEY_WIDTH-1:0]          key_ext;
  logic [PTR_W-1:0]              cur_slot;
  logic [PTR_W-1:0]              front_dec;
  logic [PTR_W-1:0]              front_inc;
  logic                          hit;
  logic                          scan_issue;
  logic                          shift_issue;
  logic [CNT_W-1:0]              hit_next;

  logic                          wr_en;
  logic [PTR_W-1:0]              wr_addr;
  logic [KEY_WIDTH-1:0]          wr_data;
  logic                          rd_en;
  logic [PTR_W-1:0]              rd_addr;
  logic [KEY_WIDTH-1:0]          rd_data;

  sdq_store #(
    .DEPTH (DEPTH),
    .WIDTH (KEY_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Decode request context
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign full        = (occ >= CNT_W'(DEPTH));
  assign empty       = (occ == '0);
  assign key_ext     = KEY_WIDTH'(key_in);
  assign cur_slot    = slot_of(front, pos);
  assign front_dec   = (front == '0) ? PTR_W'(DEPTH - 1) : front - PTR_W'(1);
  assign front_inc   = (front == PTR_W'(DEPTH - 1)) ? '0 : front + PTR_W'(1);
  assign hit         = (rd_data == key_r);
  assign scan_issue  = !(chk_vld && (hit || chk_pos == '0));
  assign shift_issue = (pos < occ);
  assign hit_next    = chk_pos + CNT_W'(1);

  // Steer the store ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = front;
    wr_en   = 1'b0;
    wr_addr = sh_dst;
    wr_data = rd_data;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            sdq_pkg::REQ_PUSH_FRONT: begin
              wr_en   = !full;
              wr_addr = front_dec;
              wr_data = key_ext;
            end
            sdq_pkg::REQ_PUSH_BACK: begin
              wr_en   = !full;
              wr_addr = slot_of(front, occ);
              wr_data = key_ext;
            end
            sdq_pkg::REQ_POP_FRONT, sdq_pkg::REQ_PEEK_FRONT: begin
              rd_en   = !empty;
              rd_addr = front;
            end
            sdq_pkg::REQ_POP_BACK, sdq_pkg::REQ_PEEK_BACK: begin
              rd_en   = !empty;
              rd_addr = slot_of(front, occ - CNT_W'(1));
            end
            default: begin
              rd_en = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = cur_slot;
      end
      S_SHIFT: begin
        wr_en   = sh_vld;
        wr_addr = sh_dst;
        wr_data = rd_data;
        rd_en   = shift_issue;
        rd_addr = cur_slot;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Sequence one request at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      occ       <= '0;
      chk_vld   <= 1'b0;
      sh_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the output beat once taken, unless the next one loads now
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_r      <= req_type;
            key_r      <= key_ext;
            res_value  <= '0;
            res_found  <= 1'b0;
            chk_vld    <= 1'b0;
            sh_vld     <= 1'b0;
            pos        <= occ - CNT_W'(1);
            if (req_type inside {sdq_pkg::REQ_PUSH_FRONT, sdq_pkg::REQ_PUSH_BACK}) begin
              state <= S_DONE;
              if (full) begin
                res_status <= sdq_pkg::ST_FULL;
              end else begin
                res_status <= sdq_pkg::ST_OK;
                occ        <= occ + CNT_W'(1);
                if (req_type == sdq_pkg::REQ_PUSH_FRONT) begin
                  front <= front_dec;
                end
              end
            end else if (req_type inside {sdq_pkg::REQ_POP_FRONT, sdq_pkg::REQ_POP_BACK,
                                          sdq_pkg::REQ_PEEK_FRONT,
                                          sdq_pkg::REQ_PEEK_BACK}) begin
              if (empty) begin
                res_status <= sdq_pkg::ST_EMPTY;
                state      <= S_DONE;
              end else begin
                res_status <= sdq_pkg::ST_OK;
                state      <= S_READ;
              end
            end else begin
              res_status <= sdq_pkg::ST_OK;
              if (empty) begin
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_READ: begin
          res_value <= sdq_pkg::VALUE_W'(rd_data);
          if (req_r == sdq_pkg::REQ_POP_FRONT) begin
            front <= front_inc;
            occ   <= occ - CNT_W'(1);
          end else if (req_r == sdq_pkg::REQ_POP_BACK) begin
            occ <= occ - CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // compare the entry read last cycle, else read the next one frontward
          if (chk_vld && hit) begin
            res_value <= sdq_pkg::VALUE_W'(rd_data);
            res_found <= 1'b1;
            chk_vld   <= 1'b0;
            if (req_r == sdq_pkg::REQ_REMOVE) begin
              if (hit_next < occ) begin
                pos   <= hit_next;
                state <= S_SHIFT;
              end else begin
                occ   <= occ - CNT_W'(1);
                state <= S_DONE;
              end
            end else begin
              state <= S_DONE;
            end
          end else if (chk_vld && chk_pos == '0) begin
            chk_vld <= 1'b0;
            state   <= S_DONE;
          end else begin
            chk_vld  <= 1'b1;
            chk_pos  <= pos;
            chk_slot <= cur_slot;
            pos      <= pos - CNT_W'(1);
          end
        end
        S_SHIFT: begin
          // move each entry behind the gap one slot frontward
          if (shift_issue) begin
            sh_vld   <= 1'b1;
            sh_dst   <= chk_slot;
            chk_slot <= cur_slot;
            pos      <= pos + CNT_W'(1);
          end else begin
            sh_vld <= 1'b0;
            occ    <= occ - CNT_W'(1);
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          // load the output beat when the register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            value_out   <= res_value;
            found       <= res_found;
            status      <= res_status;
            entry_count <= sdq_pkg::COUNT_W'(occ);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
